[rtl/e2r_pkg.sv]
`timescale 1ns / 1ps

package e2r_pkg;

	localparam int ANGLE_BITS = 16;
	localparam int ENTRY_BITS = 16;
	localparam int QF = 30;
	localparam int ANGLE_SHIFT = QF - (ANGLE_BITS - 4);
	localparam int ENTRY_SHIFT = QF - (ENTRY_BITS - 2);
	localparam int TERMS = 6;
	localparam int SC_LATENCY = 16;
	localparam int LATENCY = SC_LATENCY + 4;

	localparam logic signed [ENTRY_BITS-1:0] ENTRY_MAX = ENTRY_BITS'(1 << (ENTRY_BITS - 2));

	typedef struct packed {
		logic signed [ANGLE_BITS-1:0] angle_one;
		logic signed [ANGLE_BITS-1:0] angle_two;
		logic signed [ANGLE_BITS-1:0] angle_three;
	} angles_t;

	typedef struct packed {
		logic signed [ENTRY_BITS-1:0] r00;
		logic signed [ENTRY_BITS-1:0] r01;
		logic signed [ENTRY_BITS-1:0] r02;
		logic signed [ENTRY_BITS-1:0] r10;
		logic signed [ENTRY_BITS-1:0] r11;
		logic signed [ENTRY_BITS-1:0] r12;
		logic signed [ENTRY_BITS-1:0] r20;
		logic signed [ENTRY_BITS-1:0] r21;
		logic signed [ENTRY_BITS-1:0] r22;
	} matrix_t;

	localparam int SIN_SH [TERMS] = '{34, 36, 37, 38, 38, 39};
	localparam int COS_SH [TERMS] = '{32, 35, 36, 37, 38, 39};

	localparam logic [31:0] SIN_RCP [TERMS] = '{
		32'(((64'd1 << 34) + 64'd5) / 64'd6),
		32'(((64'd1 << 36) + 64'd19) / 64'd20),
		32'(((64'd1 << 37) + 64'd41) / 64'd42),
		32'(((64'd1 << 38) + 64'd71) / 64'd72),
		32'(((64'd1 << 38) + 64'd109) / 64'd110),
		32'(((64'd1 << 39) + 64'd155) / 64'd156)
	};

	localparam logic [31:0] COS_RCP [TERMS] = '{
		32'(((64'd1 << 32) + 64'd1) / 64'd2),
		32'(((64'd1 << 35) + 64'd11) / 64'd12),
		32'(((64'd1 << 36) + 64'd29) / 64'd30),
		32'(((64'd1 << 37) + 64'd55) / 64'd56),
		32'(((64'd1 << 38) + 64'd89) / 64'd90),
		32'(((64'd1 << 39) + 64'd131) / 64'd132)
	};

	function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic        neg;
		logic [31:0] ua;
		logic [31:0] ub;
		logic [63:0] p;
		logic [31:0] m;
		neg = a[31] ^ b[31];
		ua = a[31] ? (~a + 32'd1) : a;
		ub = b[31] ? (~b + 32'd1) : b;
		p = ua * ub;
		m = 32'((p + (64'd1 << (QF - 1))) >> QF);
		mulq = neg ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [ENTRY_BITS-1:0] to_entry(input logic signed [32:0] v);
		logic                  neg;
		logic [32:0]           u;
		logic [32:0]           rnd;
		logic [ENTRY_BITS-1:0] mag;
		neg = v[32];
		u = neg ? (~v + 33'd1) : v;
		rnd = (u + (33'd1 << (ENTRY_SHIFT - 1))) >> ENTRY_SHIFT;
		if (rnd > (33'd1 << (ENTRY_BITS - 2))) begin
			rnd = 33'd1 << (ENTRY_BITS - 2);
		end
		mag = ENTRY_BITS'(rnd);
		to_entry = neg ? -$signed(mag) : $signed(mag);
	endfunction

endpackage

[rtl/euler_to_rotation_matrix_unit.sv]
`timescale 1ns / 1ps

// Channel   Ports                     Handshake
// request   start, busy, req          taken when start is high and busy is low
// result    done, rsp                 done marks rsp for one cycle, no backpressure
//
// A request passes through the 16-stage sine and cosine pipeline and then
// four stages of matrix products and rounding before done marks its result.
// One request is accepted every cycle; busy is always low.
// Reset clears only the valid bits and the warm-up count; datapath registers are not reset.

module euler_to_rotation_matrix_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  e2r_pkg::angles_t  req,
	output logic              done,
	output e2r_pkg::matrix_t  rsp
);
	import e2r_pkg::*;

	localparam int WARM_W = $clog2(LATENCY + 1);

	logic               take_w;
	logic               vld_sc;
	logic               vld_sc2;
	logic               vld_sc3;
	logic signed [31:0] s1_w, c1_w, s2_w, c2_w, s3_w, c3_w;

	logic               vld_s1;
	logic signed [31:0] c1s2_s1, s1s2_s1, c1c2_s1, c2c3_s1, c2s3_s1;
	logic signed [31:0] s1c2_s1, s1s3_s1, s1c3_s1, c1s3_s1, c1c3_s1;
	logic signed [31:0] s2_s1, c3_s1, s3_s1;

	logic               vld_s2;
	logic signed [31:0] t01_s2, t02_s2, t21_s2, t22_s2;
	logic signed [31:0] c1c2_s2, s2_s2, c2c3_s2, c2s3_s2, s1c2_s2;
	logic signed [31:0] s1s3_s2, s1c3_s2, c1s3_s2, c1c3_s2;

	logic               vld_s3;
	logic signed [32:0] v00_s3, v01_s3, v02_s3, v10_s3, v11_s3;
	logic signed [32:0] v12_s3, v20_s3, v21_s3, v22_s3;

	logic               done_s4;
	matrix_t            rsp_s4;
	logic [WARM_W-1:0]  warm_q;

	assign busy = 1'b0;
	assign take_w = start && !busy;

	e2r_sincos u_sc1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (take_w),
		.angle   (req.angle_one),
		.out_vld (vld_sc),
		.sin_q30 (s1_w),
		.cos_q30 (c1_w)
	);

	e2r_sincos u_sc2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (take_w),
		.angle   (req.angle_two),
		.out_vld (vld_sc2),
		.sin_q30 (s2_w),
		.cos_q30 (c2_w)
	);

	e2r_sincos u_sc3 (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (take_w),
		.angle   (req.angle_three),
		.out_vld (vld_sc3),
		.sin_q30 (s3_w),
		.cos_q30 (c3_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done_s4 <= 1'b0;
			warm_q <= '0;
		end else begin
			vld_s1 <= vld_sc;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done_s4 <= vld_s3;
			if (warm_q != WARM_W'(LATENCY)) begin
				warm_q <= warm_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		c1s2_s1 <= mulq(c1_w, s2_w);
		s1s2_s1 <= mulq(s1_w, s2_w);
		c1c2_s1 <= mulq(c1_w, c2_w);
		c2c3_s1 <= mulq(c2_w, c3_w);
		c2s3_s1 <= mulq(c2_w, s3_w);
		s1c2_s1 <= mulq(s1_w, c2_w);
		s1s3_s1 <= mulq(s1_w, s3_w);
		s1c3_s1 <= mulq(s1_w, c3_w);
		c1s3_s1 <= mulq(c1_w, s3_w);
		c1c3_s1 <= mulq(c1_w, c3_w);
		s2_s1 <= s2_w;
		c3_s1 <= c3_w;
		s3_s1 <= s3_w;

		t01_s2 <= mulq(c1s2_s1, c3_s1);
		t02_s2 <= mulq(c1s2_s1, s3_s1);
		t21_s2 <= mulq(s1s2_s1, c3_s1);
		t22_s2 <= mulq(s1s2_s1, s3_s1);
		c1c2_s2 <= c1c2_s1;
		s2_s2 <= s2_s1;
		c2c3_s2 <= c2c3_s1;
		c2s3_s2 <= c2s3_s1;
		s1c2_s2 <= s1c2_s1;
		s1s3_s2 <= s1s3_s1;
		s1c3_s2 <= s1c3_s1;
		c1s3_s2 <= c1s3_s1;
		c1c3_s2 <= c1c3_s1;

		v00_s3 <= 33'(c1c2_s2);
		v01_s3 <= 33'(s1s3_s2) - 33'(t01_s2);
		v02_s3 <= 33'(t02_s2) + 33'(s1c3_s2);
		v10_s3 <= 33'(s2_s2);
		v11_s3 <= 33'(c2c3_s2);
		v12_s3 <= -33'(c2s3_s2);
		v20_s3 <= -33'(s1c2_s2);
		v21_s3 <= 33'(t21_s2) + 33'(c1s3_s2);
		v22_s3 <= 33'(c1c3_s2) - 33'(t22_s2);

		rsp_s4.r00 <= to_entry(v00_s3);
		rsp_s4.r01 <= to_entry(v01_s3);
		rsp_s4.r02 <= to_entry(v02_s3);
		rsp_s4.r10 <= to_entry(v10_s3);
		rsp_s4.r11 <= to_entry(v11_s3);
		rsp_s4.r12 <= to_entry(v12_s3);
		rsp_s4.r20 <= to_entry(v20_s3);
		rsp_s4.r21 <= to_entry(v21_s3);
		rsp_s4.r22 <= to_entry(v22_s3);
	end

	assign done = done_s4;
	assign rsp = rsp_s4;

	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("Result strobe without a request accepted earlier.");

	a_request_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(warm_q == WARM_W'(LATENCY)) && $past(start, LATENCY) |-> done)
		else $error("Accepted request produced no result.");

	a_units_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_sc2 == vld_sc) && (vld_sc3 == vld_sc))
		else $error("Sine and cosine units are out of step.");

	a_entry_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.r00 >= -ENTRY_MAX) && (rsp.r00 <= ENTRY_MAX) &&
		(rsp.r11 >= -ENTRY_MAX) && (rsp.r11 <= ENTRY_MAX) &&
		(rsp.r22 >= -ENTRY_MAX) && (rsp.r22 <= ENTRY_MAX) &&
		(rsp.r01 >= -ENTRY_MAX) && (rsp.r01 <= ENTRY_MAX) &&
		(rsp.r21 >= -ENTRY_MAX) && (rsp.r21 <= ENTRY_MAX))
		else $error("Matrix entry outside plus or minus one.");

endmodule

[rtl/e2r_sincos.sv]
`timescale 1ns / 1ps

module e2r_sincos (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 vld,
	input  logic signed [e2r_pkg::ANGLE_BITS-1:0] angle,
	output logic                                 out_vld,
	output logic signed [31:0]                   sin_q30,
	output logic signed [31:0]                   cos_q30
);
	import e2r_pkg::*;

	localparam logic signed [35:0] HALF_PI = 36'sd1686629713;
	localparam logic signed [35:0] QUARTER_PI = 36'sd843314856;

	logic signed [33:0] ang_w;
	logic [3:0]         cnt_w;
	logic signed [35:0] red_w;
	logic [59:0]        sq_w;

	logic               vld_s1;
	logic signed [33:0] ang_s1;
	logic signed [3:0]  quad_s1;
	logic               vld_s2;
	logic               rneg_s2;
	logic [29:0]        rmag_s2;
	logic [1:0]         quad_s2;
	logic               vld_s3;
	logic               rneg_s3;
	logic [29:0]        rmag_s3;
	logic [29:0]        r2_s3;
	logic [1:0]         quad_s3;

	logic [30:0]        us_w [TERMS+1];
	logic [30:0]        uc_w [TERMS+1];
	logic [29:0]        r2_w [TERMS+1];
	logic signed [31:0] accs_w [TERMS+1];
	logic signed [31:0] accc_w [TERMS+1];
	logic               neg_w [TERMS+1];
	logic [1:0]         quad_w [TERMS+1];
	logic               vld_w [TERMS+1];

	logic [30:0]        rs_sa [TERMS];
	logic [30:0]        rc_sa [TERMS];
	logic [29:0]        r2_sa [TERMS];
	logic signed [31:0] accs_sa [TERMS];
	logic signed [31:0] accc_sa [TERMS];
	logic               neg_sa [TERMS];
	logic [1:0]         quad_sa [TERMS];
	logic               vld_sa [TERMS];

	logic [62:0]        ps_sb [TERMS];
	logic [62:0]        pc_sb [TERMS];
	logic [29:0]        r2_sb [TERMS];
	logic signed [31:0] accs_sb [TERMS];
	logic signed [31:0] accc_sb [TERMS];
	logic               neg_sb [TERMS];
	logic [1:0]         quad_sb [TERMS];
	logic               vld_sb [TERMS];

	logic signed [31:0] ssum_w;
	logic signed [31:0] csum_w;
	logic signed [31:0] sval_w;
	logic               vld_sf;
	logic signed [31:0] sin_sf;
	logic signed [31:0] cos_sf;

	assign ang_w = 34'(angle) <<< ANGLE_SHIFT;

	// The quadrant is the number of half-pi steps that bring the angle into
	// the band from minus a quarter pi, inclusive, to plus a quarter pi, exclusive.
	always_comb begin
		cnt_w = 4'd0;
		for (int j = 0; j < 10; j++) begin
			if (36'(ang_w) >= 36'(j - 4) * HALF_PI - QUARTER_PI) begin
				cnt_w = cnt_w + 4'd1;
			end
		end
	end

	assign red_w = 36'(ang_s1) - 36'(quad_s1) * HALF_PI;
	assign sq_w = rmag_s2 * rmag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		ang_s1 <= ang_w;
		quad_s1 <= cnt_w - 4'd5;
		rneg_s2 <= red_w[35];
		rmag_s2 <= 30'(red_w[35] ? -red_w : red_w);
		quad_s2 <= quad_s1[1:0];
		rneg_s3 <= rneg_s2;
		rmag_s3 <= rmag_s2;
		r2_s3 <= 30'((61'(sq_w) + (61'd1 << (QF - 1))) >> QF);
		quad_s3 <= quad_s2;
	end

	assign us_w[0] = {1'b0, rmag_s3};
	assign uc_w[0] = 31'd1 << QF;
	assign r2_w[0] = r2_s3;
	assign accs_w[0] = '0;
	assign accc_w[0] = '0;
	assign neg_w[0] = rneg_s3;
	assign quad_w[0] = quad_s3;
	assign vld_w[0] = vld_s3;

	for (genvar i = 0; i < TERMS; i++) begin : g_term
		localparam bit ODD = (i % 2) == 1;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sa[i] <= 1'b0;
				vld_sb[i] <= 1'b0;
			end else begin
				vld_sa[i] <= vld_w[i];
				vld_sb[i] <= vld_sa[i];
			end
		end

		always_ff @(posedge clk) begin
			rs_sa[i] <= 31'((61'(us_w[i]) * 61'(r2_w[i]) + (61'd1 << (QF - 1))) >> QF);
			rc_sa[i] <= 31'((61'(uc_w[i]) * 61'(r2_w[i]) + (61'd1 << (QF - 1))) >> QF);
			if (ODD) begin
				accs_sa[i] <= accs_w[i] - $signed(32'(us_w[i]));
				accc_sa[i] <= accc_w[i] - $signed(32'(uc_w[i]));
			end else begin
				accs_sa[i] <= accs_w[i] + $signed(32'(us_w[i]));
				accc_sa[i] <= accc_w[i] + $signed(32'(uc_w[i]));
			end
			r2_sa[i] <= r2_w[i];
			neg_sa[i] <= neg_w[i];
			quad_sa[i] <= quad_w[i];

			ps_sb[i] <= 63'(rs_sa[i]) * 63'(SIN_RCP[i]);
			pc_sb[i] <= 63'(rc_sa[i]) * 63'(COS_RCP[i]);
			r2_sb[i] <= r2_sa[i];
			accs_sb[i] <= accs_sa[i];
			accc_sb[i] <= accc_sa[i];
			neg_sb[i] <= neg_sa[i];
			quad_sb[i] <= quad_sa[i];
		end

		assign us_w[i+1] = 31'(ps_sb[i] >> SIN_SH[i]);
		assign uc_w[i+1] = 31'(pc_sb[i] >> COS_SH[i]);
		assign r2_w[i+1] = r2_sb[i];
		assign accs_w[i+1] = accs_sb[i];
		assign accc_w[i+1] = accc_sb[i];
		assign neg_w[i+1] = neg_sb[i];
		assign quad_w[i+1] = quad_sb[i];
		assign vld_w[i+1] = vld_sb[i];
	end

	assign ssum_w = accs_w[TERMS] + $signed(32'(us_w[TERMS]));
	assign csum_w = accc_w[TERMS] + $signed(32'(uc_w[TERMS]));
	assign sval_w = neg_w[TERMS] ? -ssum_w : ssum_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sf <= 1'b0;
		end else begin
			vld_sf <= vld_w[TERMS];
		end
	end

	always_ff @(posedge clk) begin
		case (quad_w[TERMS])
			2'd0: begin
				sin_sf <= sval_w;
				cos_sf <= csum_w;
			end
			2'd1: begin
				sin_sf <= csum_w;
				cos_sf <= -sval_w;
			end
			2'd2: begin
				sin_sf <= -sval_w;
				cos_sf <= -csum_w;
			end
			default: begin
				sin_sf <= -csum_w;
				cos_sf <= sval_w;
			end
		endcase
	end

	assign out_vld = vld_sf;
	assign sin_q30 = sin_sf;
	assign cos_q30 = cos_sf;

endmodule

[dv/euler_to_rotation_matrix_unit_test.sv]
`timescale 1ns / 1ps

module euler_to_rotation_matrix_unit_test;
	import e2r_pkg::*;

	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint QUARTER_PI_Q30 = 64'sd843314856;
	localparam int IDLE_FREE_TAIL = 60;
	localparam int DRAIN_AT = 300;
	localparam int STALL_LIMIT = 2000;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	angles_t   req;
	logic      done;
	matrix_t   rsp;

	angles_t   pending_angles[$];
	matrix_t   expected_matrices[$];
	int        requests_sent;
	int        matrices_seen;
	int        mismatches;
	int        idle_left;
	int        stall_cycles;
	bit        drained;
	bit        failed;

	euler_to_rotation_matrix_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint fx_mul(longint a, longint b);
		longint ua;
		longint ub;
		longint p;
		ua = a < 0 ? -a : a;
		ub = b < 0 ? -b : b;
		p = (ua * ub + (64'sd1 <<< 29)) >>> 30;
		return ((a < 0) != (b < 0)) ? -p : p;
	endfunction

	function automatic void fx_sincos(input logic signed [ANGLE_BITS-1:0] angle,
		output longint sn, output longint cs);
		longint r;
		longint r2;
		longint t;
		longint s;
		longint c;
		int     q;
		r = longint'(angle) * (64'sd1 <<< (30 - (ANGLE_BITS - 4)));
		q = 0;
		while (r > QUARTER_PI_Q30) begin
			r -= HALF_PI_Q30;
			q++;
		end
		while (r < -QUARTER_PI_Q30) begin
			r += HALF_PI_Q30;
			q--;
		end
		r2 = fx_mul(r, r);
		t = r;
		s = r;
		for (int n = 2; n <= 12; n += 2) begin
			t = -(fx_mul(t, r2) / longint'(n * (n + 1)));
			s += t;
		end
		t = 64'sd1 <<< 30;
		c = t;
		for (int n = 2; n <= 12; n += 2) begin
			t = -(fx_mul(t, r2) / longint'((n - 1) * n));
			c += t;
		end
		case (q & 3)
			0: begin
				sn = s;
				cs = c;
			end
			1: begin
				sn = c;
				cs = -s;
			end
			2: begin
				sn = -s;
				cs = -c;
			end
			default: begin
				sn = -c;
				cs = s;
			end
		endcase
	endfunction

	function automatic logic signed [ENTRY_BITS-1:0] fx_entry(longint v);
		longint u;
		longint lim;
		lim = 64'sd1 <<< (ENTRY_BITS - 2);
		u = v < 0 ? -v : v;
		u = (u + (64'sd1 <<< (ENTRY_SHIFT - 1))) >>> ENTRY_SHIFT;
		if (u > lim) begin
			u = lim;
		end
		return ENTRY_BITS'(v < 0 ? -u : u);
	endfunction

	function automatic matrix_t rotation_of(angles_t a);
		longint  s1, c1, s2, c2, s3, c3;
		matrix_t m;
		fx_sincos(a.angle_one, s1, c1);
		fx_sincos(a.angle_two, s2, c2);
		fx_sincos(a.angle_three, s3, c3);
		m.r00 = fx_entry(fx_mul(c1, c2));
		m.r01 = fx_entry(-fx_mul(fx_mul(c1, s2), c3) + fx_mul(s1, s3));
		m.r02 = fx_entry(fx_mul(fx_mul(c1, s2), s3) + fx_mul(s1, c3));
		m.r10 = fx_entry(s2);
		m.r11 = fx_entry(fx_mul(c2, c3));
		m.r12 = fx_entry(-fx_mul(c2, s3));
		m.r20 = fx_entry(-fx_mul(s1, c2));
		m.r21 = fx_entry(fx_mul(fx_mul(s1, s2), c3) + fx_mul(c1, s3));
		m.r22 = fx_entry(-fx_mul(fx_mul(s1, s2), s3) + fx_mul(c1, c3));
		return m;
	endfunction

	function automatic logic signed [ANGLE_BITS-1:0] random_angle();
		case ($urandom_range(0, 3))
			0: return ANGLE_BITS'($urandom_range(0, 2 * 12868) - 12868);
			1: return ANGLE_BITS'($urandom_range(0, 2 * 400) - 400);
			default: return ANGLE_BITS'($urandom);
		endcase
	endfunction

	task automatic add_request(int a1, int a2, int a3);
		angles_t a;
		a.angle_one = ANGLE_BITS'(a1);
		a.angle_two = ANGLE_BITS'(a2);
		a.angle_three = ANGLE_BITS'(a3);
		pending_angles.push_back(a);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			requests_sent <= 0;
			idle_left <= 0;
			drained <= 1'b0;
		end else begin
			if (start && !busy) begin
				expected_matrices.push_back(rotation_of(req));
				requests_sent <= requests_sent + 1;
			end
			if (start && busy) begin
				start <= 1'b1;
			end else if (idle_left > 0) begin
				idle_left <= idle_left - 1;
				start <= 1'b0;
			end else if (pending_angles.size() == 0) begin
				start <= 1'b0;
			end else if (!drained && requests_sent >= DRAIN_AT) begin
				start <= 1'b0;
				if (!start && expected_matrices.size() == 0) begin
					drained <= 1'b1;
				end
			end else if (pending_angles.size() > IDLE_FREE_TAIL
				&& $urandom_range(0, 7) == 0) begin
				idle_left <= $urandom_range(1, 7) - 1;
				start <= 1'b0;
			end else begin
				start <= 1'b1;
				req <= pending_angles.pop_front();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			matrices_seen++;
			if (expected_matrices.size() == 0) begin
				failed = 1'b1;
				mismatches++;
				if (mismatches <= 10) begin
					$display("Unexpected matrix %h with no request outstanding.", rsp);
				end
			end else begin
				matrix_t want;
				want = expected_matrices.pop_front();
				for (int i = 0; i < 9; i++) begin
					if (rsp[(8 - i) * ENTRY_BITS +: ENTRY_BITS]
						!== want[(8 - i) * ENTRY_BITS +: ENTRY_BITS]) begin
						failed = 1'b1;
						mismatches++;
						if (mismatches <= 10) begin
							$display("Matrix %0d entry r%0d%0d: expected %0d, got %0d.",
								matrices_seen, i / 3, i % 3,
								$signed(want[(8 - i) * ENTRY_BITS +: ENTRY_BITS]),
								$signed(rsp[(8 - i) * ENTRY_BITS +: ENTRY_BITS]));
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Timed out after %0d cycles without progress.", stall_cycles);
				$display("status: fail");
				$finish;
			end
		end else begin
			stall_cycles <= 0;
		end
	end

	initial begin
		failed = 1'b0;
		mismatches = 0;
		matrices_seen = 0;
		arst_n = 1'b0;
		add_request(0, 0, 0);
		add_request(32767, 32767, 32767);
		add_request(-32768, -32768, -32768);
		add_request(32767, -32768, 0);
		add_request(6434, 0, 0);
		add_request(0, 6434, 0);
		add_request(0, 0, 6434);
		add_request(12868, -12868, 12868);
		add_request(3217, -3217, 3216);
		add_request(-3216, 3218, -3218);
		add_request(9651, 19302, -19302);
		add_request(25736, -25736, 16085);
		add_request(1, -1, 1);
		add_request(-6434, 6434, -12868);
		add_request(4096, 8192, -16384);
		add_request(21345, -29000, 30000);
		add_request(16'h5555, 16'hAAAA, 16'h5555);
		add_request(16'hAAAA, 16'h5555, 16'hAAAA);
		for (int i = 0; i < 632; i++) begin
			add_request(random_angle(), random_angle(), random_angle());
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_angles.size() == 0 && !start && expected_matrices.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		$display("Sent %0d angle triples covering extremes, quadrant edges and random angles,",
			requests_sent);
		$display("checked %0d rotation matrices with %0d mismatched entries.",
			matrices_seen, mismatches);
		if (!failed && expected_matrices.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
